// ===== rtl/tbfe_pkg.sv =====
// Shared types, constants and trit helper functions of the ternary block feature extractor.
package tbfe_pkg;

  localparam int PixW       = 8;
  localparam int CodeW      = 5;
  localparam int RowOutW    = 5;
  localparam int StripOutW  = 4;
  localparam int PosStripW  = 5;

  localparam logic [PixW-1:0] HighThrReset = 8'd170;
  localparam logic [PixW-1:0] LowThrReset  = 8'd85;

  typedef logic signed [1:0] trit_t;

  localparam trit_t TRIT_NEG  = 2'sb11;
  localparam trit_t TRIT_ZERO = 2'sb00;
  localparam trit_t TRIT_POS  = 2'sb01;

  // Element k is the trit of the k-th column of a strip, from the left.
  typedef trit_t [2:0] triple_t;

  typedef enum logic [0:0] {
    CFG_HIGH_THR = 1'b0,
    CFG_LOW_THR  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_start;
  } pix_t;

  typedef struct packed {
    cfg_reg_e        reg_index;
    logic [PixW-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [RowOutW-1:0]   row_index;
    logic [StripOutW-1:0] strip_index;
    logic [CodeW-1:0]     pixel_code;
    logic [CodeW-1:0]     hgrad_code;
    logic [CodeW-1:0]     vgrad_code;
    logic                 vgrad_valid;
    logic [CodeW-1:0]     htrans_code;
    logic                 htrans_valid;
    logic [CodeW-1:0]     vtrans_code;
    logic                 vtrans_valid;
  } res_t;

  // Position of the current pixel as seen by the code unit.
  typedef struct packed {
    logic                 emit;
    logic                 at_edge;
    logic [PosStripW-1:0] strip;
    logic [RowOutW-1:0]   row;
    logic                 row_nz;
  } pos_t;

  // Sign of the difference a - b of two trits.
  function automatic trit_t trit_diff_sgn(trit_t a, trit_t b);
    trit_t r;
    if ($signed(a) > $signed(b)) begin
      r = TRIT_POS;
    end else if ($signed(a) < $signed(b)) begin
      r = TRIT_NEG;
    end else begin
      r = TRIT_ZERO;
    end
    return r;
  endfunction

  // Maps a trit to t + 1.
  function automatic logic [1:0] trit_digit(trit_t t);
    return {t == TRIT_POS, t == TRIT_ZERO};
  endfunction

  // Block code 9(a+1) + 3(b+1) + (c+1) of a strip's three trits.
  function automatic logic [CodeW-1:0] trit_enc(triple_t t);
    logic [CodeW-1:0] d0;
    logic [CodeW-1:0] d1;
    logic [CodeW-1:0] d2;
    d0 = CodeW'(trit_digit(t[0]));
    d1 = CodeW'(trit_digit(t[1]));
    d2 = CodeW'(trit_digit(t[2]));
    return CodeW'(5'd9 * d0) + CodeW'(5'd3 * d1) + d2;
  endfunction

endpackage

// ===== rtl/tbfe_stream_if.sv =====
// Valid/ready channel carrying one payload per transaction.
interface tbfe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tbfe_quant.sv =====
// Threshold registers and the pixel-to-trit quantizer.
module tbfe_quant (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  tbfe_stream_if.sink                cfg_i,
  input  logic [tbfe_pkg::PixW-1:0]  pixel_i,
  output tbfe_pkg::trit_t            trit_o
);

  logic [tbfe_pkg::PixW-1:0] high_thr_q;
  logic [tbfe_pkg::PixW-1:0] low_thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= tbfe_pkg::HighThrReset;
      low_thr_q  <= tbfe_pkg::LowThrReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.reg_index)
        tbfe_pkg::CFG_HIGH_THR: high_thr_q <= cfg_i.data.wdata;
        tbfe_pkg::CFG_LOW_THR:  low_thr_q  <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // The high threshold wins when both comparisons hold.
  always_comb begin
    if (pixel_i > high_thr_q) begin
      trit_o = tbfe_pkg::TRIT_POS;
    end else if (pixel_i < low_thr_q) begin
      trit_o = tbfe_pkg::TRIT_NEG;
    end else begin
      trit_o = tbfe_pkg::TRIT_ZERO;
    end
  end

endmodule

// ===== rtl/tbfe_pos.sv =====
// Column, strip and row counters that decide which pixel closes a strip.
module tbfe_pos #(
  parameter int IMAGE_WIDTH    = 28,
  parameter int IMAGE_HEIGHT   = 28,
  parameter int STRIPS_PER_ROW = 9
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           frame_start_i,
  output tbfe_pkg::pos_t pos_o,
  output logic           emit_col_o
);

  localparam int ColW   = $clog2(IMAGE_WIDTH);
  localparam int RowW   = $clog2(IMAGE_HEIGHT);
  localparam int MaxStr = (IMAGE_WIDTH / 3 > STRIPS_PER_ROW) ? IMAGE_WIDTH / 3 : STRIPS_PER_ROW;
  localparam int StripW = $clog2(MaxStr + 1);

  localparam logic [ColW-1:0]   LastCol = ColW'(IMAGE_WIDTH - 1);
  localparam logic [RowW-1:0]   LastRow = RowW'(IMAGE_HEIGHT - 1);
  localparam logic [StripW-1:0] NumStr  = StripW'(STRIPS_PER_ROW);
  localparam logic [StripW-1:0] OneStr  = StripW'(1);

  // Column count, its value mod 3 and its value div 3 advance together.
  logic [ColW-1:0]   col_q,   col_d,   col_e;
  logic [1:0]        phase_q, phase_d, phase_e;
  logic [StripW-1:0] strip_q, strip_d, strip_e;
  logic [RowW-1:0]   row_q,   row_d,   row_e;
  logic              last_col;
  logic              norm_hit;
  logic              edge_hit;
  logic [StripW-1:0] strip_sel;

  // A strip closes at the first pixel after it, or at its last pixel when it
  // ends the row.
  function automatic logic normal_close(logic [1:0] ph, logic [StripW-1:0] st);
    return (ph == 2'd0) && (st != '0) && ((st - OneStr) < NumStr);
  endfunction

  function automatic logic edge_close(logic [ColW-1:0] c, logic [1:0] ph,
                                      logic [StripW-1:0] st);
    return (c == LastCol) && (ph == 2'd2) && (st < NumStr);
  endfunction

  always_comb begin
    col_e    = frame_start_i ? '0 : col_q;
    phase_e  = frame_start_i ? '0 : phase_q;
    strip_e  = frame_start_i ? '0 : strip_q;
    row_e    = frame_start_i ? '0 : row_q;
    last_col = (col_e == LastCol);
    norm_hit = normal_close(phase_e, strip_e);
    edge_hit = edge_close(col_e, phase_e, strip_e);
    strip_sel = norm_hit ? (strip_e - OneStr) : strip_e;

    pos_o.emit    = norm_hit || edge_hit;
    pos_o.at_edge = edge_hit;
    pos_o.strip   = tbfe_pkg::PosStripW'(strip_sel);
    pos_o.row     = tbfe_pkg::RowOutW'(row_e);
    pos_o.row_nz  = (row_e != '0);
  end

  // A frame start only removes emissions, so this is a safe bound for ready.
  assign emit_col_o = normal_close(phase_q, strip_q) || edge_close(col_q, phase_q, strip_q);

  always_comb begin
    if (last_col) begin
      col_d   = '0;
      phase_d = '0;
      strip_d = '0;
      row_d   = (row_e == LastRow) ? '0 : row_e + RowW'(1);
    end else begin
      col_d = col_e + ColW'(1);
      row_d = row_e;
      if (phase_e == 2'd2) begin
        phase_d = '0;
        strip_d = strip_e + OneStr;
      end else begin
        phase_d = phase_e + 2'd1;
        strip_d = strip_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      phase_q <= '0;
      strip_q <= '0;
      row_q   <= '0;
    end else if (accept_i) begin
      col_q   <= col_d;
      phase_q <= phase_d;
      strip_q <= strip_d;
      row_q   <= row_d;
    end
  end

endmodule

// ===== rtl/tbfe_codes.sv =====
// Combinational code unit: block, gradient and transition codes of one strip.
module tbfe_codes (
  input  tbfe_pkg::triple_t hist_i,
  input  tbfe_pkg::trit_t   trit_i,
  input  tbfe_pkg::pos_t    pos_i,
  input  tbfe_pkg::triple_t above_i,
  input  tbfe_pkg::triple_t left_i,
  output tbfe_pkg::triple_t cur_o,
  output tbfe_pkg::res_t    res_o
);

  tbfe_pkg::trit_t   win [4];
  tbfe_pkg::triple_t hg;
  tbfe_pkg::triple_t vg;
  tbfe_pkg::triple_t ht;
  logic              strip_nz;

  always_comb begin
    win[0] = hist_i[0];
    win[1] = hist_i[1];
    win[2] = hist_i[2];
    win[3] = trit_i;

    // A strip that ends the row closes on its own last pixel, one step earlier.
    for (int k = 0; k < 3; k++) begin
      cur_o[k] = pos_i.at_edge ? win[k+1] : win[k];
    end

    hg[0] = tbfe_pkg::trit_diff_sgn(cur_o[1], cur_o[0]);
    hg[1] = tbfe_pkg::trit_diff_sgn(cur_o[2], cur_o[1]);
    hg[2] = pos_i.at_edge ? tbfe_pkg::TRIT_ZERO : tbfe_pkg::trit_diff_sgn(win[3], cur_o[2]);

    // The row above is held as strip trits, so the vertical gradient and the
    // vertical transition see the same neighbors.
    for (int k = 0; k < 3; k++) begin
      vg[k] = tbfe_pkg::trit_diff_sgn(cur_o[k], above_i[k]);
      ht[k] = tbfe_pkg::trit_diff_sgn(cur_o[k], left_i[k]);
    end

    strip_nz = (pos_i.strip != '0);

    res_o.row_index    = pos_i.row;
    res_o.strip_index  = tbfe_pkg::StripOutW'(pos_i.strip);
    res_o.pixel_code   = tbfe_pkg::trit_enc(cur_o);
    res_o.hgrad_code   = tbfe_pkg::trit_enc(hg);
    res_o.vgrad_code   = pos_i.row_nz ? tbfe_pkg::trit_enc(vg) : '0;
    res_o.vgrad_valid  = pos_i.row_nz;
    res_o.htrans_code  = strip_nz ? tbfe_pkg::trit_enc(ht) : '0;
    res_o.htrans_valid = strip_nz;
    res_o.vtrans_code  = pos_i.row_nz ? tbfe_pkg::trit_enc(vg) : '0;
    res_o.vtrans_valid = pos_i.row_nz;
  end

endmodule

// ===== rtl/ternary_block_feature_extractor.sv =====
// Top level of the ternary block feature extractor.
// Takes one pixel per clock and returns one result transaction per closed
// three-pixel strip, registered in the cycle after the pixel that closes it. The
// rate is one pixel per cycle while ready is high, set by the single pass
// from the pixel input through the quantizer and the code unit into the result
// register. Input ready drops only when the next pixel would close a strip while
// the previous result is still held by the sink; other pixels pass under a held
// result. The row above is kept as one trit triple per strip; after reset it is
// unknown until a first full row has gone by, which is when it is first read, so
// no clearing pass takes place.
module ternary_block_feature_extractor #(
  parameter int IMAGE_WIDTH    = 28,
  parameter int IMAGE_HEIGHT   = 28,
  parameter int STRIPS_PER_ROW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbfe_stream_if.sink   pix_i,
  tbfe_stream_if.source res_o,
  tbfe_stream_if.sink   cfg_i
);

  localparam int SIdxW = (STRIPS_PER_ROW > 1) ? $clog2(STRIPS_PER_ROW) : 1;

  tbfe_pkg::trit_t   trit;
  tbfe_pkg::pos_t    pos;
  logic              emit_col;
  logic              pix_acc;
  tbfe_pkg::triple_t hist_q, hist_d;
  tbfe_pkg::triple_t left_q;
  tbfe_pkg::triple_t above_q [STRIPS_PER_ROW];
  tbfe_pkg::triple_t above_rd;
  tbfe_pkg::triple_t cur;
  tbfe_pkg::res_t    res_d, res_q;
  logic              res_valid_q;
  logic [SIdxW-1:0]  strip_idx;

  tbfe_quant u_quant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .pixel_i (pix_i.data.pixel),
    .trit_o  (trit)
  );

  tbfe_pos #(
    .IMAGE_WIDTH    (IMAGE_WIDTH),
    .IMAGE_HEIGHT   (IMAGE_HEIGHT),
    .STRIPS_PER_ROW (STRIPS_PER_ROW)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (pix_acc),
    .frame_start_i (pix_i.data.frame_start),
    .pos_o         (pos),
    .emit_col_o    (emit_col)
  );

  assign strip_idx = pos.strip[SIdxW-1:0];
  assign above_rd  = above_q[strip_idx];

  tbfe_codes u_codes (
    .hist_i  (hist_q),
    .trit_i  (trit),
    .pos_i   (pos),
    .above_i (above_rd),
    .left_i  (left_q),
    .cur_o   (cur),
    .res_o   (res_d)
  );

  assign pix_i.ready = !(emit_col && res_valid_q && !res_o.ready);
  assign pix_acc     = pix_i.valid && pix_i.ready;

  assign hist_d[0] = hist_q[1];
  assign hist_d[1] = hist_q[2];
  assign hist_d[2] = trit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (pix_acc) begin
      hist_q <= hist_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc && pos.emit) begin
      above_q[strip_idx] <= cur;
      left_q             <= cur;
      res_q              <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pix_acc && pos.emit) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

  // A new result only appears after an accepted pixel.
  a_result_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(pix_i.valid && pix_i.ready))
    else $error("result appeared without an accepted pixel");

  // Input back-pressure comes only from a result held by the sink.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_i.ready |-> (res_valid_q && !res_o.ready && emit_col))
    else $error("input stalled without a held result");

  // Both vertical outputs depend on the same row-above condition.
  a_vertical_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.vgrad_valid == res_q.vtrans_valid))
    else $error("vertical valid flags disagree");

endmodule

// ===== dv/tbfe_strip_checker.sv =====
// Checker that predicts the strip results of the ternary feature extractor and compares them.
module tbfe_strip_checker #(
  parameter int IMAGE_WIDTH    = 28,
  parameter int IMAGE_HEIGHT   = 28,
  parameter int STRIPS_PER_ROW = 9
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pix_valid_i,
  input  logic           pix_ready_i,
  input  tbfe_pkg::pix_t pix_data_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  tbfe_pkg::cfg_t cfg_data_i,
  input  logic           res_valid_i,
  input  logic           res_ready_i,
  input  tbfe_pkg::res_t res_data_i,
  output int             mismatches_o,
  output int             pending_o
);

  logic [tbfe_pkg::PixW-1:0]  high_thr;
  logic [tbfe_pkg::PixW-1:0]  low_thr;
  tbfe_pkg::trit_t            above_trits [IMAGE_WIDTH];
  logic [tbfe_pkg::CodeW-1:0] above_codes [STRIPS_PER_ROW];
  tbfe_pkg::trit_t            recent [4];
  logic [tbfe_pkg::CodeW-1:0] left_strip_code;
  int unsigned                col_pos;
  int unsigned                row_pos;
  tbfe_pkg::res_t             strips_due [$];

  function automatic tbfe_pkg::trit_t quantize(logic [tbfe_pkg::PixW-1:0] px,
                                               logic [tbfe_pkg::PixW-1:0] hi,
                                               logic [tbfe_pkg::PixW-1:0] lo);
    if (px > hi) begin
      return tbfe_pkg::TRIT_POS;
    end else if (px < lo) begin
      return tbfe_pkg::TRIT_NEG;
    end
    return tbfe_pkg::TRIT_ZERO;
  endfunction

  function automatic tbfe_pkg::trit_t sign_of(int v);
    if (v > 0) begin
      return tbfe_pkg::TRIT_POS;
    end else if (v < 0) begin
      return tbfe_pkg::TRIT_NEG;
    end
    return tbfe_pkg::TRIT_ZERO;
  endfunction

  function automatic logic [tbfe_pkg::CodeW-1:0] block_code(tbfe_pkg::trit_t a,
                                                            tbfe_pkg::trit_t b,
                                                            tbfe_pkg::trit_t c);
    return tbfe_pkg::CodeW'(9 * (int'(a) + 1) + 3 * (int'(b) + 1) + int'(c) + 1);
  endfunction

  // Recovers trit k (0 is the leftmost column) from a block code.
  function automatic tbfe_pkg::trit_t code_trit(logic [tbfe_pkg::CodeW-1:0] code, int k);
    int q;
    q = int'(code) % 27;
    if (k == 0) begin
      return tbfe_pkg::trit_t'(q / 9 - 1);
    end else if (k == 1) begin
      return tbfe_pkg::trit_t'((q / 3) % 3 - 1);
    end
    return tbfe_pkg::trit_t'(q % 3 - 1);
  endfunction

  task automatic clear_state();
    high_thr        = tbfe_pkg::HighThrReset;
    low_thr         = tbfe_pkg::LowThrReset;
    left_strip_code = '0;
    col_pos         = 0;
    row_pos         = 0;
    foreach (above_trits[i]) above_trits[i] = tbfe_pkg::TRIT_ZERO;
    foreach (above_codes[i]) above_codes[i] = '0;
    foreach (recent[i]) recent[i] = tbfe_pkg::TRIT_ZERO;
    strips_due.delete();
    mismatches_o = 0;
  endtask

  task automatic advance_pixel(input tbfe_pkg::pix_t p);
    tbfe_pkg::trit_t tr [3];
    tbfe_pkg::trit_t hg [3];
    tbfe_pkg::trit_t vg [3];
    tbfe_pkg::trit_t ht [3];
    tbfe_pkg::trit_t vt [3];
    tbfe_pkg::trit_t above;
    int unsigned     strip;
    int unsigned     x;
    int              k;
    int              off;
    bit              fire;
    bit              at_end;
    tbfe_pkg::res_t  r;
    fire   = 1'b0;
    at_end = 1'b0;
    strip  = 0;
    if (p.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    for (k = 0; k < 3; k++) recent[k] = recent[k+1];
    recent[3] = quantize(p.pixel, high_thr, low_thr);

    // A strip closes on the pixel right after it, or on its own last pixel
    // when it ends exactly at the right border of the image.
    if (col_pos >= 3 && col_pos % 3 == 0 && col_pos / 3 - 1 < STRIPS_PER_ROW) begin
      strip = col_pos / 3 - 1;
      fire  = 1'b1;
    end else if (col_pos == IMAGE_WIDTH - 1 && col_pos >= 2 && (col_pos - 2) % 3 == 0 &&
                 (col_pos - 2) / 3 < STRIPS_PER_ROW) begin
      strip  = (col_pos - 2) / 3;
      fire   = 1'b1;
      at_end = 1'b1;
    end

    if (fire) begin
      off = at_end ? 1 : 0;
      for (k = 0; k < 3; k++) tr[k] = recent[k+off];
      hg[0] = sign_of(int'(tr[1]) - int'(tr[0]));
      hg[1] = sign_of(int'(tr[2]) - int'(tr[1]));
      hg[2] = at_end ? tbfe_pkg::TRIT_ZERO : sign_of(int'(recent[3]) - int'(tr[2]));
      for (k = 0; k < 3; k++) begin
        x     = 3 * strip + k;
        above = (x < IMAGE_WIDTH) ? above_trits[x] : tbfe_pkg::TRIT_ZERO;
        vg[k] = sign_of(int'(tr[k]) - int'(above));
        ht[k] = sign_of(int'(tr[k]) - int'(code_trit(left_strip_code, k)));
        vt[k] = sign_of(int'(tr[k]) - int'(code_trit(above_codes[strip], k)));
      end
      r.row_index    = tbfe_pkg::RowOutW'(row_pos);
      r.strip_index  = tbfe_pkg::StripOutW'(strip);
      r.pixel_code   = block_code(tr[0], tr[1], tr[2]);
      r.hgrad_code   = block_code(hg[0], hg[1], hg[2]);
      r.vgrad_valid  = row_pos > 0;
      r.vgrad_code   = r.vgrad_valid ? block_code(vg[0], vg[1], vg[2]) : '0;
      r.htrans_valid = strip > 0;
      r.htrans_code  = r.htrans_valid ? block_code(ht[0], ht[1], ht[2]) : '0;
      r.vtrans_valid = row_pos > 0;
      r.vtrans_code  = r.vtrans_valid ? block_code(vt[0], vt[1], vt[2]) : '0;
      strips_due.push_back(r);
      for (k = 0; k < 3; k++) begin
        x = 3 * strip + k;
        if (x < IMAGE_WIDTH) above_trits[x] = tr[k];
      end
      above_codes[strip] = r.pixel_code;
      left_strip_code    = r.pixel_code;
    end

    col_pos++;
    if (col_pos >= IMAGE_WIDTH) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= IMAGE_HEIGHT) row_pos = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  task automatic compare_strip(input tbfe_pkg::res_t got);
    tbfe_pkg::res_t want;
    if (strips_due.size() == 0) begin
      $error("result transaction with nothing expected: row %0d strip %0d",
             got.row_index, got.strip_index);
      mismatches_o++;
    end else begin
      want = strips_due.pop_front();
      check_field("row_index", 8'(want.row_index), 8'(got.row_index));
      check_field("strip_index", 8'(want.strip_index), 8'(got.strip_index));
      check_field("pixel_code", 8'(want.pixel_code), 8'(got.pixel_code));
      check_field("hgrad_code", 8'(want.hgrad_code), 8'(got.hgrad_code));
      check_field("vgrad_code", 8'(want.vgrad_code), 8'(got.vgrad_code));
      check_field("vgrad_valid", 8'(want.vgrad_valid), 8'(got.vgrad_valid));
      check_field("htrans_code", 8'(want.htrans_code), 8'(got.htrans_code));
      check_field("htrans_valid", 8'(want.htrans_valid), 8'(got.htrans_valid));
      check_field("vtrans_code", 8'(want.vtrans_code), 8'(got.vtrans_code));
      check_field("vtrans_valid", 8'(want.vtrans_valid), 8'(got.vtrans_valid));
    end
  endtask

  // All three channels are sampled on the rising edge, before the block updates.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_data_i.reg_index)
          tbfe_pkg::CFG_HIGH_THR: high_thr = cfg_data_i.wdata;
          tbfe_pkg::CFG_LOW_THR:  low_thr  = cfg_data_i.wdata;
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) advance_pixel(pix_data_i);
      if (res_valid_i && res_ready_i) compare_strip(res_data_i);
    end
    pending_o = strips_due.size();
  end

endmodule

// ===== dv/ternary_block_feature_extractor_test.sv =====
// Top of the testbench: clock, reset, stimulus and verdict for the ternary feature extractor.
module ternary_block_feature_extractor_test;

  localparam int CycleLimit = 200000;
  localparam int PhaseCount = 8;
  localparam int PhaseLen   = 244;

  // Pixels around both default thresholds, the extremes, and two frame starts.
  localparam logic [7:0] SweepPx [24] = '{
    8'd0,   8'd255, 8'd170, 8'd171, 8'd85,  8'd84,  8'd86,  8'd169,
    8'd255, 8'd255, 8'd0,   8'd0,   8'd128, 8'd84,  8'd171, 8'd85,
    8'd255, 8'd0,   8'd170, 8'd86,  8'd1,   8'd254, 8'd127, 8'd170
  };
  // Threshold settings per phase; the last two phases draw their own.
  localparam logic [7:0] PhaseHigh [PhaseCount] = '{
    8'd170, 8'd255, 8'd0, 8'd0, 8'd255, 8'd127, 8'd100, 8'd170
  };
  localparam logic [7:0] PhaseLow [PhaseCount] = '{
    8'd85, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd200, 8'd85
  };

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   pending;
  bit   pix_rush;

  tbfe_stream_if #(.payload_t(tbfe_pkg::pix_t)) pix_ch ();
  tbfe_stream_if #(.payload_t(tbfe_pkg::res_t)) res_ch ();
  tbfe_stream_if #(.payload_t(tbfe_pkg::cfg_t)) cfg_ch ();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ternary_block_feature_extractor DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .pix_i  (pix_ch),
    .res_o  (res_ch),
    .cfg_i  (cfg_ch)
  );

  tbfe_strip_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .pix_valid_i  (pix_ch.valid),
    .pix_ready_i  (pix_ch.ready),
    .pix_data_i   (pix_ch.data),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_data_i   (cfg_ch.data),
    .res_valid_i  (res_ch.valid),
    .res_ready_i  (res_ch.ready),
    .res_data_i   (res_ch.data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Biased toward the thresholds so that every trit value shows up often.
  function automatic logic [7:0] pick_pixel(logic [7:0] hi, logic [7:0] lo);
    case ($urandom_range(0, 5))
      0: return hi + 8'($urandom_range(0, 2)) - 8'd1;
      1: return lo + 8'($urandom_range(0, 2)) - 8'd1;
      2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic push_pixel(input tbfe_pkg::pix_t item);
    int gap;
    if ($urandom_range(0, 29) == 0) pix_rush = !pix_rush;
    gap = pix_rush ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= item;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
  endtask

  task automatic program_thresholds(input logic [7:0] hi, input logic [7:0] lo);
    tbfe_pkg::cfg_t wr [2];
    wr[0].reg_index = tbfe_pkg::CFG_HIGH_THR;
    wr[0].wdata     = hi;
    wr[1].reg_index = tbfe_pkg::CFG_LOW_THR;
    wr[1].wdata     = lo;
    foreach (wr[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= wr[i];
      do @(posedge clk); while (!cfg_ch.ready);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every predicted strip has come out, plus the result register delay.
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    tbfe_pkg::pix_t item;
    logic [7:0]     hi;
    logic [7:0]     lo;
    int             serial;
    rst_n        = 1'b0;
    pix_rush     = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed sweep under the reset thresholds, restarting the frame mid-row.
    foreach (SweepPx[i]) begin
      item.pixel       = SweepPx[i];
      item.frame_start = (i == 0 || i == 15);
      push_pixel(item);
    end

    serial = 0;
    for (int ph = 0; ph < PhaseCount; ph++) begin
      hi = PhaseHigh[ph];
      lo = PhaseLow[ph];
      if (ph >= PhaseCount - 2) begin
        hi = 8'($urandom_range(0, 255));
        lo = 8'($urandom_range(0, 255));
      end
      pix_ch.valid <= 1'b0;
      settle();
      program_thresholds(hi, lo);
      // The early stream runs unbroken through a whole image so the row wraps;
      // later on, frame starts land at random columns.
      for (int i = 0; i < PhaseLen; i++) begin
        item.pixel       = pick_pixel(hi, lo);
        item.frame_start = (serial >= 1100) && ($urandom_range(0, 79) == 0);
        serial++;
        push_pixel(item);
      end
    end

    pix_ch.valid <= 1'b0;
    settle();
    repeat (16) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** ternary_block_feature_extractor: PASSED **");
    end else begin
      $display("** ternary_block_feature_extractor: FAILED **");
    end
    $finish;
  end

  // Result side: random stalls, bursts without stalls, and two long hold-offs that
  // back the block up into its pixel input.
  initial begin : result_sink
    int gap;
    int taken;
    bit rush;
    taken        = 0;
    rush         = 1'b0;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rush = !rush;
      if (taken == 40 || taken == 300) begin
        gap = 400;
      end else begin
        gap = rush ? 0 : $urandom_range(0, 12);
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("** ternary_block_feature_extractor: FAILED **");
    $finish;
  end

endmodule
